/* hw/rtl/kcs_pkg.sv */
// Shared types, codes and helper functions for the tape pulse modulator.
// Used by kcs_pulse_len, kcs_core and kcs_tape_pulse_modulator_top; no dependencies.
package kcs_pkg;

    // Command codes carried in the func field.
    localparam logic [1:0] FN_TICK    = 2'd0;
    localparam logic [1:0] FN_BYTE    = 2'd1;
    localparam logic [1:0] FN_PILOT   = 2'd2;
    localparam logic [1:0] FN_SILENCE = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_PILOT_TSTATES = 3'd0;
    localparam logic [2:0] CFG_ONE_TSTATES   = 3'd1;
    localparam logic [2:0] CFG_ZERO_TSTATES  = 3'd2;
    localparam logic [2:0] CFG_BIT_FORMAT    = 3'd3;
    localparam logic [2:0] CFG_BYTE_FORMAT   = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [15:0] PILOT_TSTATES_RST = 16'd729;
    localparam logic [15:0] ONE_TSTATES_RST   = 16'd729;
    localparam logic [15:0] ZERO_TSTATES_RST  = 16'd1458;
    localparam logic [7:0]  BIT_FORMAT_RST    = 8'd36;
    localparam logic [7:0]  BYTE_FORMAT_RST   = 8'd84;

    localparam logic signed [7:0] LEVEL_POS = 8'sd127;
    localparam logic signed [7:0] LEVEL_NEG = -8'sd127;

    // Samples per second are counted against milliseconds.
    localparam int MS_DIV = 1000;

    // Cycles the pulse length converters need to settle after a register write.
    localparam logic [1:0] SETTLE_CYCLES = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_PILOT   = 4'b0010,
        ST_BYTE    = 4'b0100,
        ST_SILENCE = 4'b1000
    } stage_t;

    typedef struct packed {
        logic        keep_level;
        logic [15:0] count;
        logic [7:0]  data_byte;
        logic [1:0]  func;
    } item_t;

    typedef struct packed {
        logic              accepted;
        logic              busy_res;
        logic signed [7:0] sample;
    } res_t;

    typedef struct packed {
        logic [7:0] bit_format;
        logic [7:0] byte_format;
    } fmt_t;

    // Number of bit slots in one framed byte.
    function automatic logic [3:0] frame_len(input logic [7:0] byte_format);
        frame_len = {2'b00, byte_format[7:6]} + 4'd8 + {2'b00, byte_format[4:3]};
    endfunction

    // Value of one bit slot of a framed byte.
    function automatic logic slot_value(input logic [7:0] byte_format,
                                        input logic [7:0] shift_byte,
                                        input logic [3:0] slot);
        logic [3:0] starts;
        logic [3:0] d;
        logic [2:0] pos;
        starts = {2'b00, byte_format[7:6]};
        d      = slot - starts;
        pos    = byte_format[0] ? (3'd7 - d[2:0]) : d[2:0];
        if (slot < starts) begin
            slot_value = byte_format[5];
        end
        else if (slot < starts + 4'd8) begin
            slot_value = shift_byte[pos];
        end
        else begin
            slot_value = byte_format[2];
        end
    endfunction

    // Pulses per bit from a nibble; zero stands for sixteen.
    function automatic logic [4:0] nibble_pulses(input logic [3:0] nib);
        nibble_pulses = (nib == 4'd0) ? 5'd16 : {1'b0, nib};
    endfunction

endpackage

/* hw/rtl/kcs_pulse_len.sv */
// Converts a pulse length in source clock states to output samples,
// floor(tstates * SAMPLE_RATE / SOURCE_CLOCK) clamped to one, over two stages.
// Depends on kcs_pkg.
module kcs_pulse_len
    import kcs_pkg::*;
#(
    parameter int SAMPLE_RATE  = 96000,
    parameter int SOURCE_CLOCK = 3500000,
    parameter int SW           = 11
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [15:0]   tstates,
    output logic [SW-1:0] samples
);

    // Reciprocal scaled far enough that the rounding error never crosses an integer.
    localparam int SHIFT = 16 + $clog2(SOURCE_CLOCK);
    localparam longint unsigned MULT =
        ((longint'(SAMPLE_RATE) << SHIFT) + longint'(SOURCE_CLOCK) - 1) / SOURCE_CLOCK;
    localparam int KW  = $clog2(MULT + 1);
    localparam int LOW = (KW + 1) / 2;
    localparam int HIW = KW - LOW;
    localparam int PW  = 16 + KW + 1;
    localparam logic [KW-1:0]  K_VEC = KW'(MULT);
    localparam logic [LOW-1:0] K_LO  = K_VEC[LOW-1:0];
    localparam logic [HIW-1:0] K_HI  = K_VEC[KW-1:LOW];

    logic [16+LOW-1:0] p_lo_reg, p_lo_next;
    logic [16+HIW-1:0] p_hi_reg, p_hi_next;
    logic [SW-1:0]     samples_reg, samples_next;
    logic [PW-1:0]     sum;
    logic [PW-1:0]     quot;

    assign p_lo_next = (16+LOW)'(tstates) * (16+LOW)'(K_LO);
    assign p_hi_next = (16+HIW)'(tstates) * (16+HIW)'(K_HI);

    always_comb
    begin
        sum  = ({{(PW-16-HIW){1'b0}}, p_hi_reg} << LOW) + PW'(p_lo_reg);
        quot = sum >> SHIFT;
        samples_next = SW'(quot);
        if (samples_next == '0)
        begin
            samples_next = SW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_lo_reg    <= '0;
            p_hi_reg    <= '0;
            samples_reg <= '0;
        end
        else
        begin
            p_lo_reg    <= p_lo_next;
            p_hi_reg    <= p_hi_next;
            samples_reg <= samples_next;
        end
    end

    assign samples = samples_reg;

endmodule

/* hw/rtl/kcs_core.sv */
// Waveform state machine: pilot, framed byte and silence sequencing, one item per step.
// Depends on kcs_pkg; pulse lengths come from kcs_pulse_len instances.
module kcs_core
    import kcs_pkg::*;
#(
    parameter int SAMPLE_RATE = 96000,
    parameter int SW          = 11
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  item_t         item,
    input  fmt_t          fmt,
    input  logic [SW-1:0] pilot_len,
    input  logic [SW-1:0] one_len,
    input  logic [SW-1:0] zero_len,
    output res_t          res
);

    // Silence is tracked as SAMPLE_RATE * ms minus MS_DIV per tick.
    localparam longint unsigned SIL_MAX = longint'(SAMPLE_RATE) * 65535;
    localparam int RW = $clog2(SIL_MAX + 1);

    stage_t        stage_reg, stage_next;
    logic          neg_reg, neg_next;
    logic [15:0]   pilot_left_reg, pilot_left_next;
    logic [3:0]    bit_slot_reg, bit_slot_next;
    logic [4:0]    pulses_left_reg, pulses_left_next;
    logic [SW-1:0] samples_left_reg, samples_left_next;
    logic [7:0]    shift_byte_reg, shift_byte_next;
    logic [RW-1:0] silence_reg, silence_next;

    logic [SW-1:0] samples_dec;
    logic [RW-1:0] silence_total;
    logic [3:0]    new_slot;
    logic [7:0]    new_byte;
    logic          new_val;
    logic          new_end;
    logic          cur_val;
    logic          is_tick;

    always_comb
    begin
        is_tick       = (item.func == FN_TICK);
        samples_dec   = samples_left_reg - SW'(1);
        silence_total = RW'(SAMPLE_RATE) * RW'(item.count);
        cur_val       = slot_value(fmt.byte_format, shift_byte_reg, bit_slot_reg);
        // A new bit starts either at slot zero of a queued byte or at the next slot.
        new_slot      = is_tick ? (bit_slot_reg + 4'd1) : 4'd0;
        new_byte      = is_tick ? shift_byte_reg : item.data_byte;
        new_val       = slot_value(fmt.byte_format, new_byte, new_slot);
        new_end       = (new_slot >= frame_len(fmt.byte_format));
    end

    always_comb
    begin
        stage_next        = stage_reg;
        neg_next          = neg_reg;
        pilot_left_next   = pilot_left_reg;
        bit_slot_next     = bit_slot_reg;
        pulses_left_next  = pulses_left_reg;
        samples_left_next = samples_left_reg;
        shift_byte_next   = shift_byte_reg;
        silence_next      = silence_reg;
        res.sample        = 8'sd0;
        res.accepted      = 1'b0;

        if (step)
        begin
            if (is_tick)
            begin
                unique case (stage_reg)
                    ST_SILENCE:
                    begin
                        silence_next = silence_reg - RW'(MS_DIV);
                        if (silence_reg < RW'(2 * MS_DIV))
                        begin
                            stage_next = ST_IDLE;
                        end
                    end
                    ST_PILOT, ST_BYTE:
                    begin
                        res.sample        = neg_reg ? LEVEL_NEG : LEVEL_POS;
                        samples_left_next = samples_dec;
                        if (samples_dec == '0)
                        begin
                            neg_next = ~neg_reg;
                            if (stage_reg == ST_PILOT)
                            begin
                                pilot_left_next   = pilot_left_reg - 16'd1;
                                samples_left_next = pilot_len;
                                if (pilot_left_reg == 16'd1)
                                begin
                                    stage_next = ST_IDLE;
                                end
                            end
                            else if (pulses_left_reg != 5'd1)
                            begin
                                pulses_left_next  = pulses_left_reg - 5'd1;
                                samples_left_next = cur_val ? one_len : zero_len;
                            end
                            else
                            begin
                                bit_slot_next = new_slot;
                                if (new_end)
                                begin
                                    stage_next = ST_IDLE;
                                end
                                else
                                begin
                                    pulses_left_next = new_val
                                        ? nibble_pulses(fmt.bit_format[3:0])
                                        : nibble_pulses(fmt.bit_format[7:4]);
                                    samples_left_next = new_val ? one_len : zero_len;
                                end
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (stage_reg == ST_IDLE)
            begin
                res.accepted = 1'b1;
                unique case (item.func)
                    FN_BYTE:
                    begin
                        // A frame always holds at least the eight data bits.
                        shift_byte_next   = item.data_byte;
                        bit_slot_next     = new_slot;
                        stage_next        = ST_BYTE;
                        pulses_left_next  = new_val ? nibble_pulses(fmt.bit_format[3:0])
                                                    : nibble_pulses(fmt.bit_format[7:4]);
                        samples_left_next = new_val ? one_len : zero_len;
                    end
                    FN_PILOT:
                    begin
                        if (!item.keep_level)
                        begin
                            neg_next = 1'b0;
                        end
                        if (item.count != 16'd0)
                        begin
                            pilot_left_next   = item.count;
                            samples_left_next = pilot_len;
                            stage_next        = ST_PILOT;
                        end
                    end
                    FN_SILENCE:
                    begin
                        if (item.count != 16'd0)
                        begin
                            neg_next     = 1'b0;
                            silence_next = silence_total;
                            if (silence_total >= RW'(MS_DIV))
                            begin
                                stage_next = ST_SILENCE;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        res.busy_res = (stage_next != ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg        <= ST_IDLE;
            neg_reg          <= 1'b0;
            pilot_left_reg   <= '0;
            bit_slot_reg     <= '0;
            pulses_left_reg  <= '0;
            samples_left_reg <= '0;
            shift_byte_reg   <= '0;
            silence_reg      <= '0;
        end
        else
        begin
            stage_reg        <= stage_next;
            neg_reg          <= neg_next;
            pilot_left_reg   <= pilot_left_next;
            bit_slot_reg     <= bit_slot_next;
            pulses_left_reg  <= pulses_left_next;
            samples_left_reg <= samples_left_next;
            shift_byte_reg   <= shift_byte_next;
            silence_reg      <= silence_next;
        end
    end

endmodule

/* hw/rtl/kcs_tape_pulse_modulator_top.sv */
// Top level of the tape pulse modulator: configuration registers, input and result
// registers, pulse length converters and the waveform core.
// Depends on kcs_pkg, kcs_pulse_len and kcs_core.
//
//  Channel  Direction  Handshake              Contents
//  s_*      in         s_tvalid / s_tready    one command or tick item
//  m_*      out        m_tvalid / m_tready    one result item per input item
//  cfg_*    in         cfg_we, no wait        register write by index
//
// One item enters per cycle while s_tready is high, via the input register.
// The result register frees as m_tready is seen, so a stall at the output holds the
// input register and then s_tready, without losing or repeating an item.
// s_tready is low after reset, during every register write and after it, while the
// two-stage pulse length converters settle.
// Reset is asynchronous and active low; it restores the register defaults.
module kcs_tape_pulse_modulator_top
    import kcs_pkg::*;
#(
    parameter int SAMPLE_RATE  = 96000,
    parameter int SOURCE_CLOCK = 3500000
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // data_byte [7:0], count [23:8]
    input  logic [2:0]  s_tuser,   // func [1:0], keep_level [2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // sample [7:0]
    output logic [1:0]  m_tuser,   // busy_res [0], accepted [1]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    localparam longint unsigned LEN_MAX =
        (longint'(65535) * longint'(SAMPLE_RATE)) / longint'(SOURCE_CLOCK);
    localparam int SW = (LEN_MAX < 1) ? 1 : $clog2(LEN_MAX + 1);

    logic [15:0] pilot_ts_reg, one_ts_reg, zero_ts_reg;
    fmt_t        fmt_reg;
    logic [1:0]  hold_reg, hold_next;
    logic        in_valid_reg, in_valid_next;
    item_t       in_item_reg;
    logic        out_valid_reg, out_valid_next;
    res_t        out_res_reg;

    logic          advance;
    logic          take;
    item_t         s_item;
    res_t          core_res;
    logic [SW-1:0] pilot_len, one_len, zero_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pilot_ts_reg        <= PILOT_TSTATES_RST;
            one_ts_reg          <= ONE_TSTATES_RST;
            zero_ts_reg         <= ZERO_TSTATES_RST;
            fmt_reg.bit_format  <= BIT_FORMAT_RST;
            fmt_reg.byte_format <= BYTE_FORMAT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_PILOT_TSTATES: pilot_ts_reg        <= cfg_wdata;
                CFG_ONE_TSTATES:   one_ts_reg          <= cfg_wdata;
                CFG_ZERO_TSTATES:  zero_ts_reg         <= cfg_wdata;
                CFG_BIT_FORMAT:    fmt_reg.bit_format  <= cfg_wdata[7:0];
                CFG_BYTE_FORMAT:   fmt_reg.byte_format <= cfg_wdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    kcs_pulse_len #(
        .SAMPLE_RATE  (SAMPLE_RATE),
        .SOURCE_CLOCK (SOURCE_CLOCK),
        .SW           (SW)
    ) u_pilot_len (
        .clk     (clk),
        .rst_n   (rst_n),
        .tstates (pilot_ts_reg),
        .samples (pilot_len)
    );

    kcs_pulse_len #(
        .SAMPLE_RATE  (SAMPLE_RATE),
        .SOURCE_CLOCK (SOURCE_CLOCK),
        .SW           (SW)
    ) u_one_len (
        .clk     (clk),
        .rst_n   (rst_n),
        .tstates (one_ts_reg),
        .samples (one_len)
    );

    kcs_pulse_len #(
        .SAMPLE_RATE  (SAMPLE_RATE),
        .SOURCE_CLOCK (SOURCE_CLOCK),
        .SW           (SW)
    ) u_zero_len (
        .clk     (clk),
        .rst_n   (rst_n),
        .tstates (zero_ts_reg),
        .samples (zero_len)
    );

    always_comb
    begin
        s_item.func       = s_tuser[1:0];
        s_item.keep_level = s_tuser[2];
        s_item.data_byte  = s_tdata[7:0];
        s_item.count      = s_tdata[23:8];

        advance  = in_valid_reg && (!out_valid_reg || m_tready);
        s_tready = (!in_valid_reg || advance) && (hold_reg == 2'd0) && !cfg_we;
        take     = s_tvalid && s_tready;

        in_valid_next  = take || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !m_tready);

        if (cfg_we)
        begin
            hold_next = SETTLE_CYCLES;
        end
        else if (hold_reg != 2'd0)
        begin
            hold_next = hold_reg - 2'd1;
        end
        else
        begin
            hold_next = hold_reg;
        end
    end

    kcs_core #(
        .SAMPLE_RATE (SAMPLE_RATE),
        .SW          (SW)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (in_item_reg),
        .fmt       (fmt_reg),
        .pilot_len (pilot_len),
        .one_len   (one_len),
        .zero_len  (zero_len),
        .res       (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg      <= SETTLE_CYCLES;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hold_reg      <= hold_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_item_reg <= s_item;
        end
        if (advance)
        begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg.sample;
    assign m_tuser  = {out_res_reg.accepted, out_res_reg.busy_res};

endmodule

/* tb/kcs_tape_pulse_modulator_top_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for kcs_tape_pulse_modulator_top: sends command and tick items,
// predicts every result item with its own waveform model and checks it field by field.
// Depends on kcs_pkg and the kcs_tape_pulse_modulator_top RTL.
module kcs_tape_pulse_modulator_top_test;
    import kcs_pkg::*;

    localparam int RATE_HZ     = 96000;
    localparam int SRC_HZ      = 3500000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 275;

    class kcs_wave_scoreboard;
        logic [15:0]       pilot_ts;
        logic [15:0]       one_ts;
        logic [15:0]       zero_ts;
        logic [7:0]        bit_fmt;
        logic [7:0]        byte_fmt;
        logic signed [7:0] level;
        stage_t            stage;
        int unsigned       pilot_left;
        int unsigned       slot;
        int unsigned       pulses_left;
        int unsigned       samples_left;
        int unsigned       silence_left;
        logic [7:0]        shift_byte;
        res_t              waveform_q[$];
        int                errors;

        function new();
            pilot_ts     = PILOT_TSTATES_RST;
            one_ts       = ONE_TSTATES_RST;
            zero_ts      = ZERO_TSTATES_RST;
            bit_fmt      = BIT_FORMAT_RST;
            byte_fmt     = BYTE_FORMAT_RST;
            level        = LEVEL_POS;
            stage        = ST_IDLE;
            pilot_left   = 0;
            slot         = 0;
            pulses_left  = 0;
            samples_left = 0;
            silence_left = 0;
            shift_byte   = '0;
            errors       = 0;
        endfunction

        function void write_reg(logic [2:0] addr, logic [15:0] value);
            case (addr)
                CFG_PILOT_TSTATES: pilot_ts = value;
                CFG_ONE_TSTATES:   one_ts   = value;
                CFG_ZERO_TSTATES:  zero_ts  = value;
                CFG_BIT_FORMAT:    bit_fmt  = value[7:0];
                CFG_BYTE_FORMAT:   byte_fmt = value[7:0];
                default: ;
            endcase
        endfunction

        // Samples per pulse; a length that rounds down to nothing still lasts one sample.
        function int unsigned pulse_len(logic [15:0] tstates);
            longint unsigned n;
            n = tstates;
            n = (n * RATE_HZ) / SRC_HZ;
            return (n == 0) ? 1 : int'(n);
        endfunction

        function int unsigned frame_slots();
            return byte_fmt[7:6] + 8 + byte_fmt[4:3];
        endfunction

        function logic bit_value(int unsigned s);
            int unsigned starts;
            int unsigned d;
            starts = byte_fmt[7:6];
            if (s < starts)
                return byte_fmt[5];
            if (s < starts + 8)
            begin
                d = s - starts;
                return byte_fmt[0] ? shift_byte[7 - d] : shift_byte[d];
            end
            return byte_fmt[2];
        endfunction

        function void start_bit();
            if (slot >= frame_slots())
            begin
                stage = ST_IDLE;
                return;
            end
            if (bit_value(slot))
            begin
                pulses_left  = bit_fmt[3:0];
                samples_left = pulse_len(one_ts);
            end
            else
            begin
                pulses_left  = bit_fmt[7:4];
                samples_left = pulse_len(zero_ts);
            end
            if (pulses_left == 0)
                pulses_left = 16;
        endfunction

        function logic signed [7:0] tick_once();
            logic signed [7:0] smp;
            if (stage == ST_SILENCE)
            begin
                silence_left--;
                if (silence_left == 0)
                    stage = ST_IDLE;
                return '0;
            end
            if (stage == ST_IDLE)
                return '0;
            smp = level;
            samples_left--;
            if (samples_left != 0)
                return smp;
            level = -level;
            if (stage == ST_PILOT)
            begin
                pilot_left--;
                if (pilot_left == 0)
                    stage = ST_IDLE;
                else
                    samples_left = pulse_len(pilot_ts);
                return smp;
            end
            pulses_left--;
            if (pulses_left != 0)
            begin
                samples_left = bit_value(slot) ? pulse_len(one_ts) : pulse_len(zero_ts);
                return smp;
            end
            slot++;
            start_bit();
            return smp;
        endfunction

        function void note_input(item_t it);
            res_t            r;
            longint unsigned n;
            r = '0;
            if (it.func == FN_TICK)
                r.sample = tick_once();
            else if (stage == ST_IDLE)
            begin
                r.accepted = 1'b1;
                case (it.func)
                    FN_BYTE:
                    begin
                        shift_byte = it.data_byte;
                        slot       = 0;
                        stage      = ST_BYTE;
                        start_bit();
                    end
                    FN_PILOT:
                    begin
                        if (!it.keep_level)
                            level = LEVEL_POS;
                        if (it.count != 0)
                        begin
                            pilot_left   = it.count;
                            samples_left = pulse_len(pilot_ts);
                            stage        = ST_PILOT;
                        end
                    end
                    FN_SILENCE:
                    begin
                        if (it.count != 0)
                        begin
                            n            = it.count;
                            silence_left = int'((n * RATE_HZ) / MS_DIV);
                            level        = LEVEL_POS;
                            if (silence_left != 0)
                                stage = ST_SILENCE;
                        end
                    end
                    default: ;
                endcase
            end
            r.busy_res = (stage != ST_IDLE);
            waveform_q.push_back(r);
        endfunction

        function void check_result(logic signed [7:0] sample, logic busy, logic acc);
            res_t want;
            if (waveform_q.size() == 0)
            begin
                $error("result item with nothing expected: sample %0d", sample);
                errors++;
                return;
            end
            want = waveform_q.pop_front();
            if (sample !== want.sample)
            begin
                $error("sample: expected %0d, got %0d", want.sample, sample);
                errors++;
            end
            if (busy !== want.busy_res)
            begin
                $error("busy_res: expected %0d, got %0d", want.busy_res, busy);
                errors++;
            end
            if (acc !== want.accepted)
            begin
                $error("accepted: expected %0d, got %0d", want.accepted, acc);
                errors++;
            end
        endfunction

        function bit is_busy();
            return stage != ST_IDLE;
        endfunction

        function int pending();
            return waveform_q.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // data_byte [7:0], count [23:8]
    logic [2:0]  s_tuser;   // func [1:0], keep_level [2]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;   // sample [7:0]
    logic [1:0]  m_tuser;   // busy_res [0], accepted [1]
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [15:0] cfg_wdata;

    int send_idle_pct;
    int recv_idle_pct;

    kcs_wave_scoreboard sb;

    kcs_tape_pulse_modulator_top #(
        .SAMPLE_RATE  (RATE_HZ),
        .SOURCE_CLOCK (SRC_HZ)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser[0], m_tuser[1]);
    end

    function automatic item_t make_item(logic [1:0] func, logic [7:0] data_byte,
                                        logic [15:0] count, logic keep_level);
        item_t it;
        it.func       = func;
        it.data_byte  = data_byte;
        it.count      = count;
        it.keep_level = keep_level;
        return it;
    endfunction

    // Mostly well-formed: commands while idle, ticks while busy, with some noise.
    function automatic item_t random_item(bit block_busy);
        item_t       it;
        int unsigned r;
        it.data_byte  = 8'($urandom_range(255, 0));
        it.count      = 16'($urandom_range(65535, 0));
        it.keep_level = 1'($urandom_range(1, 0));
        r = $urandom_range(99, 0);
        if (block_busy)
        begin
            // Commands that arrive while busy are dropped by the block.
            if (r < 92)
                it.func = FN_TICK;
            else if (r < 95)
                it.func = FN_BYTE;
            else if (r < 98)
                it.func = FN_PILOT;
            else
                it.func = FN_SILENCE;
        end
        else if (r < 5 || r >= 96)
            it.func = FN_TICK;
        else if (r < 60)
            it.func = FN_BYTE;
        else if (r < 80)
        begin
            it.func  = FN_PILOT;
            it.count = 16'($urandom_range(6, 1));
        end
        else if (r < 84)
        begin
            it.func  = FN_PILOT;
            it.count = '0;
        end
        else if (r < 92)
        begin
            it.func  = FN_SILENCE;
            it.count = ($urandom_range(9, 0) == 0) ? 16'd2 : 16'd1;
        end
        else
        begin
            it.func  = FN_SILENCE;
            it.count = '0;
        end
        return it;
    endfunction

    task automatic send_item(input item_t it);
        s_tvalid <= 1'b1;
        s_tdata  <= {it.count, it.data_byte};
        s_tuser  <= {it.keep_level, it.func};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(it);
    endtask

    task automatic sender_gap();
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic tick_until_idle();
        while (sb.is_busy())
            send_item(make_item(FN_TICK, 8'($urandom_range(255, 0)),
                                16'($urandom_range(65535, 0)), 1'($urandom_range(1, 0))));
    endtask

    // Stops sending and waits until every result item has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_regs(input logic [15:0] pilot_ts, one_ts, zero_ts,
                              input logic [7:0] bit_fmt, byte_fmt);
        logic [2:0]  addrs [5];
        logic [15:0] vals [5];
        addrs = '{CFG_PILOT_TSTATES, CFG_ONE_TSTATES, CFG_ZERO_TSTATES, CFG_BIT_FORMAT,
                  CFG_BYTE_FORMAT};
        vals  = '{pilot_ts, one_ts, zero_ts, {8'h00, bit_fmt}, {8'h00, byte_fmt}};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_addr  <= addrs[i];
            cfg_wdata <= vals[i];
            sb.write_reg(addrs[i], vals[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        item_t it;
        int    counted;
        sb            = new();
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        send_idle_pct = 16;
        recv_idle_pct = 56;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Idle tick carrying all-ones fields, empty pilot and empty silence.
        send_item(make_item(FN_TICK, 8'hFF, 16'hFFFF, 1'b1));
        send_item(make_item(FN_PILOT, 8'h00, 16'h0000, 1'b0));
        send_item(make_item(FN_SILENCE, 8'h00, 16'h0000, 1'b0));
        drain_results();

        // One-sample pulses, one pulse per bit, bare eight-bit frame.
        write_regs(16'd0, 16'd0, 16'd0, 8'h11, 8'h00);
        send_item(make_item(FN_PILOT, 8'h00, 16'd2, 1'b0));
        send_item(make_item(FN_BYTE, 8'h5A, 16'h0000, 1'b0));
        tick_until_idle();
        send_item(make_item(FN_PILOT, 8'h00, 16'd1, 1'b1));
        tick_until_idle();
        send_item(make_item(FN_PILOT, 8'h00, 16'd0, 1'b0));
        send_item(make_item(FN_BYTE, 8'hFF, 16'h0000, 1'b0));
        tick_until_idle();
        send_item(make_item(FN_BYTE, 8'h00, 16'hFFFF, 1'b1));
        tick_until_idle();

        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            case (p)
                0: write_regs(PILOT_TSTATES_RST, ONE_TSTATES_RST, ZERO_TSTATES_RST,
                              BIT_FORMAT_RST, BYTE_FORMAT_RST);
                1: write_regs(16'd0, 16'd0, 16'd40, 8'h21, 8'hFB);
                2: write_regs(16'd100, 16'd37, 16'd0, 8'h10, 8'h02);
                3: write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
                4: write_regs(16'd37, 16'd72, 16'd73, 8'h12, 8'h5C);
                default: write_regs(16'($urandom_range(150, 0)), 16'($urandom_range(150, 0)),
                                    16'($urandom_range(150, 0)), 8'($urandom_range(255, 0)),
                                    8'($urandom_range(255, 0)));
            endcase
            if (p < 2)
            begin
                send_idle_pct = 16;
                recv_idle_pct = 56;
            end
            else if (p < 4)
            begin
                send_idle_pct = 56;
                recv_idle_pct = 16;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                sender_gap();
                it = random_item(sb.is_busy());
                if (it.func == FN_TICK || !sb.is_busy())
                    counted++;
                send_item(it);
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("kcs_tape_pulse_modulator_top_test: clean");
        else
            $display("kcs_tape_pulse_modulator_top_test: errors");
        $finish;
    end

    initial
    begin
        #(5_000_000);
        $display("kcs_tape_pulse_modulator_top_test: errors");
        $finish;
    end

endmodule
